// ----- hw/rtl/ect_pkg.sv -----
`default_nettype none

package ect_pkg;

   // Field widths
   localparam int TS_W     = 32;
   localparam int LEN_W    = 16;
   localparam int DAYS_W   = 16;   // 2^32 / 86400 < 2^16
   localparam int REM_W    = 17;   // seconds of day < 86400
   localparam int DOE_W    = 18;   // day of era < 146097
   localparam int YOE_W    = 9;    // year of era < 400
   localparam int DOY_W    = 9;    // day of year < 366
   localparam int MP_W     = 4;    // March-based month 0..11
   localparam int R2_W     = 12;   // seconds of hour < 3600

   localparam logic [TS_W-1:0]  MIN_VALID_RESET = 32'h6774_1501;
   localparam logic [LEN_W-1:0] MIN_PAYLOAD_LEN = 16'd4;

   // Pipeline depths of the three units
   localparam int SPLIT_LAT  = 2;
   localparam int CLK_LAT    = 3;
   localparam int CIV_LAT    = 7;
   localparam int CLK_PAD    = CIV_LAT - CLK_LAT;
   localparam int PIPE_DEPTH = SPLIT_LAT + CIV_LAT + 1;

   // Reciprocal multipliers: floor(x/d) = (x * ceil(2^k/d)) >> k, exact when x*d <= 2^k.
   // Days: (ts >> 7) / 675 == ts / 86400
   localparam int DAY_SHIFT_LO = 7;
   localparam int DAY_X_W      = TS_W - DAY_SHIFT_LO;
   localparam int DAY_K        = 35;
   localparam longint DAY_DIV  = 675;
   localparam int DAY_M_W      = 26;
   localparam logic [DAY_M_W-1:0] DAY_M =
      DAY_M_W'(((64'd1 << DAY_K) + DAY_DIV - 1) / DAY_DIV);

   localparam int HOUR_K      = 29;
   localparam longint HOUR_DIV = 3600;
   localparam int HOUR_M_W    = 18;
   localparam logic [HOUR_M_W-1:0] HOUR_M =
      HOUR_M_W'(((64'd1 << HOUR_K) + HOUR_DIV - 1) / HOUR_DIV);

   localparam int MIN_K       = 18;
   localparam longint MIN_DIV = 60;
   localparam int MIN_M_W     = 13;
   localparam logic [MIN_M_W-1:0] MIN_M =
      MIN_M_W'(((64'd1 << MIN_K) + MIN_DIV - 1) / MIN_DIV);

   localparam int WD_K        = 19;
   localparam longint WD_DIV  = 7;
   localparam int WD_M_W      = 17;
   localparam int WD_OFFSET   = 4;    // 1970-01-01 was a Thursday
   localparam logic [WD_M_W-1:0] WD_M =
      WD_M_W'(((64'd1 << WD_K) + WD_DIV - 1) / WD_DIV);

   // Era selection: only eras 4 and 5 are reachable from a 32-bit stamp
   localparam int DAYS_SHIFT   = 719468;
   localparam int DAYS_PER_ERA = 146097;
   localparam int ERA_SPLIT    = 5 * DAYS_PER_ERA - DAYS_SHIFT;
   localparam int DOE_OFS_ERA4 = DAYS_SHIFT - 4 * DAYS_PER_ERA;

   localparam int Q4Y_K        = 29;
   localparam longint Q4Y_DIV  = 1460;
   localparam int Q4Y_M_W      = 19;
   localparam logic [Q4Y_M_W-1:0] Q4Y_M =
      Q4Y_M_W'(((64'd1 << Q4Y_K) + Q4Y_DIV - 1) / Q4Y_DIV);

   localparam int CENT_DAYS    = 36524;
   localparam int ERA_LAST_DAY = 146096;

   localparam int YR_K         = 27;
   localparam longint YR_DIV   = 365;
   localparam int YR_M_W       = 19;
   localparam logic [YR_M_W-1:0] YR_M =
      YR_M_W'(((64'd1 << YR_K) + YR_DIV - 1) / YR_DIV);

   localparam int C100_K       = 16;
   localparam longint C100_DIV = 100;
   localparam int C100_M_W     = 10;
   localparam logic [C100_M_W-1:0] C100_M =
      C100_M_W'(((64'd1 << C100_K) + C100_DIV - 1) / C100_DIV);

   localparam int MONTHS       = 12;
   localparam logic [MP_W-1:0] MP_JANUARY = 4'd10;
   localparam logic [7:0] YEAR_OFS_ERA4 = 8'(4 * 400 + 2048 - 2000);
   localparam logic [7:0] YEAR_OFS_ERA5 = 8'(5 * 400 - 2000);

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] weekday;
   } clk_fields_type;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
   } date_fields_type;

   // First day of each month, in days after March 1
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ect_day_split.sv -----
`default_nettype none

module ect_day_split import ect_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [TS_W-1:0]   ts,
   output logic      [DAYS_W-1:0] days,
   output logic      [REM_W-1:0]  rem
);

   logic [DAY_X_W-1:0]         x_ff;
   logic [DAY_SHIFT_LO-1:0]    lo_ff;
   logic [DAYS_W-1:0]          q1_ff, q1_in;
   logic [DAYS_W-1:0]          q2_ff;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [DAY_X_W+DAY_M_W-1:0] prod;
   logic [DAY_X_W-1:0]         back;
   logic [DAY_X_W-1:0]         hi;

   // Stage 1: quotient by reciprocal multiply
   assign prod  = {{DAY_M_W{1'b0}}, ts[TS_W-1:DAY_SHIFT_LO]} * {{DAY_X_W{1'b0}}, DAY_M};
   assign q1_in = prod[DAY_K +: DAYS_W];

   // Stage 2: remainder
   assign back   = DAY_X_W'(q1_ff) * DAY_X_W'(DAY_DIV);
   assign hi     = x_ff - back;
   assign rem_in = {hi[REM_W-DAY_SHIFT_LO-1:0], lo_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= ts[TS_W-1:DAY_SHIFT_LO];
         lo_ff  <= ts[DAY_SHIFT_LO-1:0];
         q1_ff  <= q1_in;
         q2_ff  <= q1_ff;
         rem_ff <= rem_in;
      end
   end

   assign days = q2_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ect_clock.sv -----
`default_nettype none

module ect_clock import ect_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [DAYS_W-1:0] days,
   input  wire logic [REM_W-1:0]  rem,
   output clk_fields_type         fields
);

   logic [REM_W+HOUR_M_W-1:0]  hour_prod;
   logic [DAYS_W-1:0]          dp4;
   logic [DAYS_W+WD_M_W-1:0]   wd_prod;
   logic [R2_W+MIN_M_W-1:0]    min_prod;

   logic [4:0]        hour1_ff, hour1_in;
   logic [REM_W-1:0]  rem1_ff;
   logic [DAYS_W-1:0] dp4_1_ff;
   logic [12:0]       wdq1_ff, wdq1_in;

   logic [R2_W-1:0]   r2_2_ff, r2_2_in;
   logic [4:0]        hour2_ff;
   logic [2:0]        wd2_ff, wd2_in;

   logic [5:0]        min3_ff, min3_in;
   logic [R2_W-1:0]   r2_3_ff;
   logic [4:0]        hour3_ff;
   logic [2:0]        wd3_ff;

   logic [R2_W-1:0]   sec_full;
   logic [REM_W-1:0]  hour_back;
   logic [DAYS_W-1:0] wd_back;

   // Stage 1: hour and week quotient
   assign hour_prod = {{HOUR_M_W{1'b0}}, rem} * {{REM_W{1'b0}}, HOUR_M};
   assign hour1_in  = hour_prod[HOUR_K +: 5];
   assign dp4       = days + DAYS_W'(WD_OFFSET);
   assign wd_prod   = {{WD_M_W{1'b0}}, dp4} * {{DAYS_W{1'b0}}, WD_M};
   assign wdq1_in   = wd_prod[WD_K +: 13];

   // Stage 2: seconds within hour, weekday remainder
   assign hour_back = REM_W'(hour1_ff) * REM_W'(HOUR_DIV);
   assign r2_2_in   = R2_W'(rem1_ff - hour_back);
   assign wd_back   = DAYS_W'(wdq1_ff) * DAYS_W'(WD_DIV);
   assign wd2_in    = 3'(dp4_1_ff - wd_back);

   // Stage 3: minute
   assign min_prod = {{MIN_M_W{1'b0}}, r2_2_ff} * {{R2_W{1'b0}}, MIN_M};
   assign min3_in  = min_prod[MIN_K +: 6];

   assign sec_full = r2_3_ff - R2_W'(min3_ff) * R2_W'(MIN_DIV);

   always_ff @(posedge clock) begin
      if (adv) begin
         hour1_ff <= hour1_in;
         rem1_ff  <= rem;
         dp4_1_ff <= dp4;
         wdq1_ff  <= wdq1_in;
         r2_2_ff  <= r2_2_in;
         hour2_ff <= hour1_ff;
         wd2_ff   <= wd2_in;
         min3_ff  <= min3_in;
         r2_3_ff  <= r2_2_ff;
         hour3_ff <= hour2_ff;
         wd3_ff   <= wd2_ff;
      end
   end

   assign fields.hour    = hour3_ff;
   assign fields.minute  = min3_ff;
   assign fields.second  = sec_full[5:0];
   assign fields.weekday = wd3_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ect_civil.sv -----
`default_nettype none

module ect_civil import ect_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [DAYS_W-1:0] days,
   output date_fields_type        fields
);

   // Stage 1
   logic             era5_1_ff, era5_1_in;
   logic [DOE_W-1:0] doe1_ff, doe1_in;
   // Stage 2
   logic [DOE_W+Q4Y_M_W-1:0] q4y_prod;
   logic [6:0]       a2_ff, a2_in;
   logic [2:0]       b2_ff, b2_in;
   logic             c2_ff, c2_in;
   logic [DOE_W-1:0] doe2_ff;
   logic             era5_2_ff;
   // Stage 3
   logic [DOE_W-1:0] t3_ff, t3_in;
   logic [DOE_W-1:0] doe3_ff;
   logic             era5_3_ff;
   // Stage 4
   logic [DOE_W+YR_M_W-1:0] yr_prod;
   logic [YOE_W-1:0] yoe4_ff, yoe4_in;
   logic [DOE_W-1:0] doe4_ff;
   logic             era5_4_ff;
   // Stage 5
   logic [YOE_W+C100_M_W-1:0] c100_prod;
   logic [DOE_W-1:0] p365_5_ff, p365_5_in;
   logic [1:0]       q100_5_ff, q100_5_in;
   logic [YOE_W-1:0] yoe5_ff;
   logic [DOE_W-1:0] doe5_ff;
   logic             era5_5_ff;
   // Stage 6
   logic [DOE_W-1:0] doy_full;
   logic [DOY_W-1:0] doy6_ff, doy6_in;
   logic [YOE_W-1:0] yoe6_ff;
   logic             era5_6_ff;
   // Stage 7
   logic [MP_W-1:0]  mp7_ff, mp7_in;
   logic [DOY_W-1:0] doy7_ff;
   logic [YOE_W-1:0] yoe7_ff;
   logic             era5_7_ff;

   logic [DOY_W-1:0] day_full;
   logic             jan_feb;

   // Stage 1: pick the era and the day within it
   assign era5_1_in = (days >= DAYS_W'(ERA_SPLIT));
   assign doe1_in   = era5_1_in ? DOE_W'(days) - DOE_W'(ERA_SPLIT)
                                : DOE_W'(days) + DOE_W'(DOE_OFS_ERA4);

   // Stage 2: leap-day corrections
   assign q4y_prod = {{Q4Y_M_W{1'b0}}, doe1_ff} * {{DOE_W{1'b0}}, Q4Y_M};
   assign a2_in    = q4y_prod[Q4Y_K +: 7];
   assign c2_in    = (doe1_ff >= DOE_W'(ERA_LAST_DAY));

   always_comb begin
      b2_in = '0;
      for (int i = 1; i <= 4; i++) begin
         if (doe1_ff >= DOE_W'(CENT_DAYS * i)) begin
            b2_in = b2_in + 3'd1;
         end
      end
   end

   // Stage 3
   assign t3_in = doe2_ff - DOE_W'(a2_ff) + DOE_W'(b2_ff) - DOE_W'(c2_ff);

   // Stage 4: year of era
   assign yr_prod = {{YR_M_W{1'b0}}, t3_ff} * {{DOE_W{1'b0}}, YR_M};
   assign yoe4_in = yr_prod[YR_K +: YOE_W];

   // Stage 5: days before this year
   assign p365_5_in = DOE_W'(yoe4_ff) * DOE_W'(YR_DIV);
   assign c100_prod = {{C100_M_W{1'b0}}, yoe4_ff} * {{YOE_W{1'b0}}, C100_M};
   assign q100_5_in = c100_prod[C100_K +: 2];

   // Stage 6: day of year
   assign doy_full = doe5_ff - p365_5_ff - DOE_W'(yoe5_ff[YOE_W-1:2]) + DOE_W'(q100_5_ff);
   assign doy6_in  = doy_full[DOY_W-1:0];

   // Stage 7: month search over the month-start table
   always_comb begin
      mp7_in = '0;
      for (int i = 1; i < MONTHS; i++) begin
         if (doy6_ff >= month_start(MP_W'(i))) begin
            mp7_in = MP_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         era5_1_ff <= era5_1_in;
         doe1_ff   <= doe1_in;
         a2_ff     <= a2_in;
         b2_ff     <= b2_in;
         c2_ff     <= c2_in;
         doe2_ff   <= doe1_ff;
         era5_2_ff <= era5_1_ff;
         t3_ff     <= t3_in;
         doe3_ff   <= doe2_ff;
         era5_3_ff <= era5_2_ff;
         yoe4_ff   <= yoe4_in;
         doe4_ff   <= doe3_ff;
         era5_4_ff <= era5_3_ff;
         p365_5_ff <= p365_5_in;
         q100_5_ff <= q100_5_in;
         yoe5_ff   <= yoe4_ff;
         doe5_ff   <= doe4_ff;
         era5_5_ff <= era5_4_ff;
         doy6_ff   <= doy6_in;
         yoe6_ff   <= yoe5_ff;
         era5_6_ff <= era5_5_ff;
         mp7_ff    <= mp7_in;
         doy7_ff   <= doy6_ff;
         yoe7_ff   <= yoe6_ff;
         era5_7_ff <= era5_6_ff;
      end
   end

   // January and February belong to the next calendar year
   assign jan_feb  = (mp7_ff >= MP_JANUARY);
   assign day_full = doy7_ff - month_start(mp7_ff) + DOY_W'(1);

   assign fields.day   = day_full[4:0];
   assign fields.month = jan_feb ? mp7_ff - MP_W'(9) : mp7_ff + MP_W'(3);
   assign fields.year  = yoe7_ff[7:0] + (era5_7_ff ? YEAR_OFS_ERA5 : YEAR_OFS_ERA4)
                         + 8'(jan_feb);

endmodule

`default_nettype wire

// ----- hw/rtl/epoch_to_calendar_time.sv -----
`default_nettype none

// Channel  | Dir | Beat contents
// ---------+-----+--------------------------------------------------------------
// req_     | in  | timestamp (32b), payload_length (16b)
// rsp_     | out | valid flag on tuser; year, month, day, hour, minute, second, weekday
// csr_     | in  | APB register min_valid_time at byte address 0
//
// One beat in per clock while rsp_ is not stalled; every request beat produces
// one response beat after the civil-date pipeline (seven stages after the
// two-stage day/second split, plus the output register).
// Reset clears all valid bits and loads min_valid_time with its default.
// A stall on rsp_ freezes every stage together; req_tready drops only while
// the output register holds a beat that has not been taken.

module epoch_to_calendar_time import ect_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,    // [31:0] timestamp, [47:32] payload_length

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [7:0] year_two_digit, [11:8] month,
                                          // [16:12] day, [21:17] hour, [27:22] minute,
                                          // [33:28] second, [36:34] weekday, rest zero
   output logic             rsp_tuser,    // [0] valid_res

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] REG_MIN_VALID = 2'd0;

   logic [TS_W-1:0]  min_valid_ff, min_valid_in;
   logic             csr_wr;

   logic [TS_W-1:0]  ts;
   logic [LEN_W-1:0] len;
   logic             ok_now;
   logic             adv;

   logic [PIPE_DEPTH-1:0] v_ff, v_in;
   logic [PIPE_DEPTH-2:0] ok_ff, ok_in;

   logic [DAYS_W-1:0] days;
   logic [REM_W-1:0]  rem;
   clk_fields_type    clk_out;
   date_fields_type   date_out;
   clk_fields_type    clk_pad_ff [CLK_PAD];
   clk_fields_type    clk_pad_in [CLK_PAD];

   logic [39:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tuser_ff, rsp_tuser_in;

   // Register port: writes take effect at the access phase, reads are immediate
   assign csr_pready   = 1'b1;
   assign csr_wr       = csr_psel & csr_penable & csr_pwrite & csr_pready
                         & (csr_paddr == REG_MIN_VALID);
   assign min_valid_in = csr_wr ? csr_pwdata : min_valid_ff;
   assign csr_prdata   = (csr_paddr == REG_MIN_VALID) ? min_valid_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= MIN_VALID_RESET;
      end else begin
         min_valid_ff <= min_valid_in;
      end
   end

   // Whole pipe advances unless the output beat is held
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   assign ts     = req_tdata[TS_W-1:0];
   assign len    = req_tdata[TS_W +: LEN_W];
   // Flag short payloads and stamps not past the sanity bound as invalid
   assign ok_now = (len >= MIN_PAYLOAD_LEN) && (ts > min_valid_ff);

   assign v_in  = {v_ff[PIPE_DEPTH-2:0], req_tvalid};
   assign ok_in = {ok_ff[PIPE_DEPTH-3:0], ok_now};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff <= ok_in;
      end
   end

   ect_day_split u_split (
      .clock (clock),
      .adv   (adv),
      .ts    (ts),
      .days  (days),
      .rem   (rem)
   );

   ect_clock u_clock (
      .clock  (clock),
      .adv    (adv),
      .days   (days),
      .rem    (rem),
      .fields (clk_out)
   );

   ect_civil u_civil (
      .clock  (clock),
      .adv    (adv),
      .days   (days),
      .fields (date_out)
   );

   // Delay the time-of-day fields to line up with the date
   always_comb begin
      clk_pad_in[0] = clk_out;
      for (int i = 1; i < CLK_PAD; i++) begin
         clk_pad_in[i] = clk_pad_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < CLK_PAD; i++) begin
            clk_pad_ff[i] <= clk_pad_in[i];
         end
      end
   end

   // Output register: zero every field of a rejected stamp
   always_comb begin
      rsp_tuser_in = ok_ff[PIPE_DEPTH-2];
      rsp_tdata_in = '0;
      if (rsp_tuser_in) begin
         rsp_tdata_in = {3'b000,
                         clk_pad_ff[CLK_PAD-1].weekday,
                         clk_pad_ff[CLK_PAD-1].second,
                         clk_pad_ff[CLK_PAD-1].minute,
                         clk_pad_ff[CLK_PAD-1].hour,
                         date_out.day,
                         date_out.month,
                         date_out.year};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = v_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ect_checker.sv -----
`default_nettype none

module ect_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [1:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // Held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Rejected stamps carry an all-zero date
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("rejected beat carries nonzero fields");

   // Accepted stamps carry in-range fields
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[11:8] >= 4'd1 && rsp_tdata[11:8] <= 4'd12 &&
         rsp_tdata[16:12] >= 5'd1 && rsp_tdata[21:17] <= 5'd23 &&
         rsp_tdata[27:22] <= 6'd59 && rsp_tdata[33:28] <= 6'd59 &&
         rsp_tdata[36:34] <= 3'd6 && rsp_tdata[39:37] == 3'd0)
      else $error("date field out of range");

   // Input is taken whenever the output side can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not track output stall");

   // Register reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 2'd0)
      ##1 (csr_paddr == 2'd0 && !csr_pwrite) |-> csr_prdata == $past(csr_pwdata))
      else $error("register readback mismatch");

endmodule

bind epoch_to_calendar_time ect_checker u_ect_checker (.*);

`default_nettype wire

// ----- verif/epoch_to_calendar_time_tb.sv -----
`default_nettype none

module epoch_to_calendar_time_tb;

   // Only register of the block: min_valid_time
   localparam logic [1:0] MIN_VALID_ADDR = 2'd0;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned REPORT_LIMIT = 10;

   // Broken-down date as it travels on rsp_ (valid flag from tuser)
   typedef struct packed {
      logic       valid;
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] weekday;
   } civil_time_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // [31:0] timestamp, [47:32] payload_length
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [7:0] year, [11:8] month, [16:12] day, [21:17] hour,
                              // [27:22] minute, [33:28] second, [36:34] weekday
   logic        rsp_tuser;    // [0] valid_res
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Dates predicted for accepted beats, oldest first
   civil_time_type expected_dates[$];
   // Testbench copy of min_valid_time
   logic [31:0] sync_floor;
   // Set during stretches where neither side idles
   bit          no_gaps;
   int unsigned fault_count;
   int unsigned cycle_count;
   civil_time_type got_date;
   civil_time_type want_date;

   epoch_to_calendar_time DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Convert a timestamp into a calendar date: days since 0000-03-01 split
   // into 400-year eras, years of era, March-based months. An invalid beat
   // (short payload, or stamp not past the floor) carries all zeros.
   function automatic civil_time_type civil_date(input logic [31:0] stamp,
                                                 input logic [15:0] len,
                                                 input logic [31:0] floor_stamp);
      civil_time_type r;
      logic [31:0] days, sod, z, era, doe, yoe, yr, doy, mp, dom, mon;
      r = '0;
      if (len < 16'd4 || stamp <= floor_stamp) return r;
      days = stamp / 32'd86400;
      sod  = stamp % 32'd86400;
      z    = days + 32'd719468;          // shift epoch to 0000-03-01
      era  = z / 32'd146097;
      doe  = z - era * 32'd146097;
      yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
      yr   = yoe + era * 32'd400;
      doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
      mp   = (32'd5 * doy + 32'd2) / 32'd153;
      dom  = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
      mon  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
      // January and February belong to the next civil year
      if (mon <= 32'd2) yr = yr + 32'd1;
      r.valid   = 1'b1;
      r.year    = 8'(yr - 32'd2000);
      r.month   = mon[3:0];
      r.day     = dom[4:0];
      r.hour    = 5'(sod / 32'd3600);
      r.minute  = 6'((sod % 32'd3600) / 32'd60);
      r.second  = 6'(sod % 32'd60);
      r.weekday = 3'((days + 32'd4) % 32'd7);   // 1970-01-01 was a Thursday
      return r;
   endfunction

   // Idle length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(9, 40);
   endfunction

   task automatic note_fault(input string what, input civil_time_type want,
                             input civil_time_type got);
      if (fault_count < REPORT_LIMIT) begin
         $display("%s: expected v=%0d y=%0d m=%0d d=%0d %0d:%0d:%0d wd=%0d",
                  what, want.valid, want.year, want.month, want.day, want.hour,
                  want.minute, want.second, want.weekday);
         $display("   got v=%0d y=%0d m=%0d d=%0d %0d:%0d:%0d wd=%0d",
                  got.valid, got.year, got.month, got.day, got.hour,
                  got.minute, got.second, got.weekday);
      end
      fault_count++;
   endtask

   // Send one beat after a random idle, and record its predicted date once
   // it is taken. tvalid stays high on return so back-to-back beats need no
   // second assignment in the same step.
   task automatic send_stamp(input logic [31:0] ts, input logic [15:0] len);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, ts};
      do @(posedge clock); while (!req_tready);
      expected_dates.push_back(civil_date(ts, len, sync_floor));
   endtask

   // Drop tvalid and hold until every predicted date has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   // Two-phase register write; call only with the pipeline empty
   task automatic write_floor(input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MIN_VALID_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sync_floor = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reset floor: payload length around 4 and stamps around the floor
   task automatic test_reset_floor();
      send_stamp(ect_pkg::MIN_VALID_RESET, 16'd4);
      send_stamp(ect_pkg::MIN_VALID_RESET + 32'd1, 16'd4);
      send_stamp(ect_pkg::MIN_VALID_RESET + 32'd1, 16'd3);
      send_stamp(32'hFFFF_FFFF, 16'd0);
      send_stamp(32'hFFFF_FFFF, 16'd1);
      send_stamp(32'hFFFF_FFFF, 16'd2);
      send_stamp(32'hFFFF_FFFF, 16'hFFFF);
      send_stamp(32'd0, 16'hFFFF);
   endtask

   // Lowered floor: epoch, century turn with year wrap, leap days
   task automatic test_calendar_edges();
      drain_results();
      write_floor(32'd0);
      send_stamp(32'd0, 16'd8);             // equals floor: rejected
      send_stamp(32'd1, 16'd8);             // 1970-01-01 00:00:01
      send_stamp(32'd946684799, 16'd4);     // 1999-12-31 23:59:59, year wraps
      send_stamp(32'd946684800, 16'd4);     // 2000-01-01
      send_stamp(32'd951782400, 16'd4);     // 2000-02-29
      send_stamp(32'd1709164800, 16'd4);    // 2024-02-29
      send_stamp(32'd4102444800, 16'd4);    // 2100-01-01
      send_stamp(32'd4107542400, 16'd4);    // 2100-03-01, no leap day
      send_stamp(32'hFFFF_FFFF, 16'd4);     // 2106-02-07 06:28:15
   endtask

   // Top floor: nothing can pass it
   task automatic test_floor_at_max();
      drain_results();
      write_floor(32'hFFFF_FFFF);
      send_stamp(32'hFFFF_FFFF, 16'hFFFF);
      send_stamp(32'hFFFF_FFFE, 16'd4);
   endtask

   // One random phase under a given floor; a stretch in the middle runs
   // with neither side idling
   task automatic test_random_stream(input int n_items, input logic [31:0] floor_val);
      logic [31:0] ts;
      logic [15:0] len;
      int          sel;
      int          day_no;
      drain_results();
      write_floor(floor_val);
      for (int i = 0; i < n_items; i++) begin
         no_gaps = (i >= n_items / 3) && (i < n_items / 3 + 30);
         sel = $urandom_range(0, 99);
         if (sel < 60 && sync_floor != 32'hFFFF_FFFF) begin
            ts = $urandom_range(32'hFFFF_FFFF, sync_floor + 32'd1);
         end else if (sel < 75) begin
            ts = $urandom;
         end else if (sel < 88) begin
            ts = sync_floor + 32'($urandom_range(0, 4)) - 32'd2;
         end else begin
            // midnight and one second either side
            day_no = $urandom_range(0, 49710);
            ts = 32'(day_no) * 32'd86400 + 32'($urandom_range(0, 2)) - 32'd1;
         end
         sel = $urandom_range(0, 99);
         if (sel < 70) len = 16'($urandom_range(4, 65535));
         else if (sel < 85) len = 16'($urandom_range(0, 5));
         else len = 16'($urandom);
         send_stamp(ts, len);
      end
      no_gaps = 1'b0;
   endtask

   // Result side: hold tready high for a while, then stall at random
   initial begin : rsp_pacer
      int hold;
      int stall;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rsp_tready && !no_gaps) begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               hold = stall - 1;
            end
         end else begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(0, 12);
         end
      end
   end

   // Compare each taken result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_date = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[11:8], rsp_tdata[16:12],
                     rsp_tdata[21:17], rsp_tdata[27:22], rsp_tdata[33:28],
                     rsp_tdata[36:34]};
         if (expected_dates.size() == 0) begin
            note_fault("unexpected beat", '0, got_date);
         end else begin
            want_date = expected_dates.pop_front();
            if (got_date.valid   !== want_date.valid   ||
                got_date.year    !== want_date.year    ||
                got_date.month   !== want_date.month   ||
                got_date.day     !== want_date.day     ||
                got_date.hour    !== want_date.hour    ||
                got_date.minute  !== want_date.minute  ||
                got_date.second  !== want_date.second  ||
                got_date.weekday !== want_date.weekday)
               note_fault("date mismatch", want_date, got_date);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      no_gaps     = 1'b0;
      fault_count = 0;
      sync_floor  = ect_pkg::MIN_VALID_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_floor();
      test_calendar_edges();
      test_floor_at_max();
      test_random_stream(200, ect_pkg::MIN_VALID_RESET);
      test_random_stream(200, 32'd0);
      test_random_stream(180, $urandom);
      test_random_stream(60, 32'hFFFF_FFFF);
      test_random_stream(190, 32'hFFFF_FFF0);

      // Let everything come out, then give the pipeline time to show strays
      drain_results();
      repeat (4 * ect_pkg::PIPE_DEPTH) @(posedge clock);
      if (expected_dates.size() != 0) fault_count++;

      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
